@@ rtl/core/epw_pkg.sv @@
package epw_pkg;

	localparam int TRIG_W           = 16;
	localparam int RESULT_W         = 32;
	localparam int BUFFER_DEPTH_DEF = 128;
	localparam int WIDTH_BITS_DEF   = 32;

	localparam logic [TRIG_W-1:0] TRIG_TICKS_RST = 16'd2000;

endpackage

@@ rtl/core/epw_ifs.sv @@
interface epw_in_if;
	logic valid;
	logic ready;
	logic echo_level;
	logic trigger_request;
	logic read_request;

	modport source (output valid, output echo_level, output trigger_request,
		output read_request, input ready);
	modport sink (input valid, input echo_level, input trigger_request,
		input read_request, output ready);
endinterface

interface epw_out_if;
	import epw_pkg::*;

	logic                valid;
	logic                ready;
	logic                trigger_out;
	logic                data_valid;
	logic [RESULT_W-1:0] pulse_width;
	logic                buffer_empty;
	logic                buffer_full;
	logic                width_dropped;
	logic                missing_rising;

	modport source (output valid, output trigger_out, output data_valid,
		output pulse_width, output buffer_empty, output buffer_full,
		output width_dropped, output missing_rising, input ready);
	modport sink (input valid, input trigger_out, input data_valid,
		input pulse_width, input buffer_empty, input buffer_full,
		input width_dropped, input missing_rising, output ready);
endinterface

@@ rtl/core/echo_pulse_width_fifo_unit.sv @@
// Channel   Dir  Payload                                          Transfer
// in_ch     in   echo_level, trigger_request, read_request        valid & ready
// out_ch    out  trigger_out, data_valid, pulse_width[31:0],      valid & ready
//                buffer_empty, buffer_full, width_dropped,
//                missing_rising
// cfg       in   cfg_wdata[15:0] = trigger_ticks                  cfg_we
//
// One item per clock sustained while out_ch accepts; each item yields one
// result via stage 1 and the result queue (width-store read in the accept
// cycle, result queue after). Rate is set by the combinational ring update
// and one store read per item. in_ch.ready depends only on internal
// occupancy; a 3-entry result queue absorbs output stalls. arst_n clears
// control state; the width store has no reset, and its data is used only for written entries.
module echo_pulse_width_fifo_unit #(
	parameter int BUFFER_DEPTH = epw_pkg::BUFFER_DEPTH_DEF,
	parameter int WIDTH_BITS   = epw_pkg::WIDTH_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [epw_pkg::TRIG_W-1:0]  cfg_wdata,
	epw_in_if.sink                      in_ch,
	epw_out_if.source                   out_ch
);
	import epw_pkg::*;

	localparam int IDX_W   = $clog2(BUFFER_DEPTH);
	localparam int STORE_W = (WIDTH_BITS > RESULT_W) ? RESULT_W : WIDTH_BITS;
	localparam int QDEPTH  = 3;
	localparam int QPTR_W  = 2;

	typedef struct packed {
		logic                trigger_out;
		logic                data_valid;
		logic [RESULT_W-1:0] pulse_width;
		logic                buffer_empty;
		logic                buffer_full;
		logic                width_dropped;
		logic                missing_rising;
	} res_t;

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	function automatic logic [QPTR_W-1:0] qptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// control state
	logic [TRIG_W-1:0]     trig_ticks_q;
	logic [TRIG_W-1:0]     trig_rem_q;
	logic                  prev_echo_q;
	logic                  rising_seen_q;
	logic [WIDTH_BITS-1:0] width_cnt_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic [IDX_W-1:0]      wr_idx_q;

	// width store
	logic [STORE_W-1:0]    width_mem [BUFFER_DEPTH];
	logic [STORE_W-1:0]    mem_rd_s1;

	// stage 1
	logic                  v_s1;
	res_t                  res_s1;
	logic                  byp_s1;
	logic [STORE_W-1:0]    byp_data_s1;

	// result queue
	res_t                  rq_q [QDEPTH];
	logic [QPTR_W-1:0]     rq_wr_q;
	logic [QPTR_W-1:0]     rq_rd_q;
	logic [QPTR_W-1:0]     rq_cnt_q;

	logic                  in_fire;
	logic                  out_fire;
	logic [TRIG_W-1:0]     trig_sel;
	logic                  trig_on;
	logic                  rise;
	logic                  fall;
	logic [WIDTH_BITS-1:0] width_new;
	logic                  full_now;
	logic                  push;
	logic                  pop;
	logic                  bypass;
	logic [IDX_W-1:0]      wr_new;
	logic [IDX_W-1:0]      rd_new;
	res_t                  res_d;
	res_t                  res_fin;

	assign in_ch.ready = ({1'b0, rq_cnt_q} + {2'b00, v_s1}) <= 3'd2;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_fire    = out_ch.valid && out_ch.ready;

	always_comb begin
		trig_sel  = in_ch.trigger_request ? trig_ticks_q : trig_rem_q;
		trig_on   = trig_sel != '0;
		rise      = in_ch.echo_level && !prev_echo_q;
		fall      = !in_ch.echo_level && prev_echo_q;
		if (rise) begin
			width_new = '0;
		end else if (width_cnt_q == '1) begin
			width_new = width_cnt_q;
		end else begin
			width_new = width_cnt_q + 1'b1;
		end
		full_now  = idx_next(wr_idx_q) == rd_idx_q;
		push      = fall && rising_seen_q && !full_now;
		wr_new    = push ? idx_next(wr_idx_q) : wr_idx_q;
		pop       = in_ch.read_request && (rd_idx_q != wr_new);
		// reading the slot written this cycle: ring was empty before the push
		bypass    = pop && push && (rd_idx_q == wr_idx_q);
		rd_new    = pop ? idx_next(rd_idx_q) : rd_idx_q;

		res_d.trigger_out    = trig_on;
		res_d.data_valid     = pop;
		res_d.pulse_width    = '0;
		res_d.buffer_empty   = rd_new == wr_new;
		res_d.buffer_full    = idx_next(wr_new) == rd_new;
		res_d.width_dropped  = fall && rising_seen_q && full_now;
		res_d.missing_rising = fall && !rising_seen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q  <= TRIG_TICKS_RST;
			trig_rem_q    <= '0;
			prev_echo_q   <= 1'b0;
			rising_seen_q <= 1'b0;
			width_cnt_q   <= '0;
			rd_idx_q      <= '0;
			wr_idx_q      <= '0;
		end else begin
			if (cfg_we) begin
				trig_ticks_q <= cfg_wdata;
			end
			if (in_fire) begin
				trig_rem_q    <= trig_on ? trig_sel - 1'b1 : trig_sel;
				prev_echo_q   <= in_ch.echo_level;
				rising_seen_q <= rising_seen_q || rise;
				width_cnt_q   <= width_new;
				rd_idx_q      <= rd_new;
				wr_idx_q      <= wr_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && push) begin
			width_mem[wr_idx_q] <= width_new[STORE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mem_rd_s1 <= width_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_s1      <= res_d;
			byp_s1      <= bypass;
			byp_data_s1 <= width_new[STORE_W-1:0];
		end
	end

	always_comb begin
		res_fin = res_s1;
		if (!res_s1.data_valid) begin
			res_fin.pulse_width = '0;
		end else if (byp_s1) begin
			res_fin.pulse_width = RESULT_W'(byp_data_s1);
		end else begin
			res_fin.pulse_width = RESULT_W'(mem_rd_s1);
		end
	end

	// result queue: stage 1 always drains into it, the ready rule keeps room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (v_s1) begin
				rq_wr_q <= qptr_next(rq_wr_q);
			end
			if (out_fire) begin
				rq_rd_q <= qptr_next(rq_rd_q);
			end
			rq_cnt_q <= rq_cnt_q + QPTR_W'(v_s1) - QPTR_W'(out_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			rq_q[rq_wr_q] <= res_fin;
		end
	end

	assign out_ch.valid          = rq_cnt_q != '0;
	assign out_ch.trigger_out    = rq_q[rq_rd_q].trigger_out;
	assign out_ch.data_valid     = rq_q[rq_rd_q].data_valid;
	assign out_ch.pulse_width    = rq_q[rq_rd_q].pulse_width;
	assign out_ch.buffer_empty   = rq_q[rq_rd_q].buffer_empty;
	assign out_ch.buffer_full    = rq_q[rq_rd_q].buffer_full;
	assign out_ch.width_dropped  = rq_q[rq_rd_q].width_dropped;
	assign out_ch.missing_rising = rq_q[rq_rd_q].missing_rising;

	a_rq_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> rq_cnt_q <= QPTR_W'(QDEPTH - 1))
		else $error("result queue overflow");

	a_byp_pop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && byp_s1 |-> res_s1.data_valid && !res_s1.width_dropped)
		else $error("bypass without pop");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(rd_idx_q) < BUFFER_DEPTH) && (32'(wr_idx_q) < BUFFER_DEPTH))
		else $error("ring index out of range");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !(res_s1.width_dropped && res_s1.missing_rising))
		else $error("dropped and missing flagged together");

	a_ring_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> $stable(rd_idx_q) && $stable(wr_idx_q))
		else $error("ring moved without transfer");

endmodule
